// File: hdl/pbs_pkg.sv
// Types and constants for the per-pixel background statistics core.
// Used by pixel_background_statistics_core; depends on nothing.
package pbs_pkg;

    localparam int SUM_W  = 24;
    localparam int SQ_W   = 32;
    localparam int CNT_W  = 16;
    localparam int MEAN_W = 8;
    localparam int VAR_W  = 18;

    // Variance datapath: (n*sumsq - sum^2) * 16 over n^2.
    localparam int PROD_W = 48;
    localparam int DNUM_W = 52;
    localparam int VREM_W = 50;
    localparam int NN_W   = 32;

    localparam int MEAN_STEPS = 8;
    localparam int VAR_STEPS  = 18;

    localparam logic [MEAN_W-1:0] MEAN_MAX   = 8'd255;
    localparam logic [VAR_W-1:0]  VAR_MAX    = 18'd262143;
    localparam logic [VAR_W-1:0]  VAR_OFFSET = 18'd160;

    // Result queue; also bounds the number of queries in flight.
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = 5;

    typedef enum logic {
        OP_ACCUM = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [2:0][SQ_W-1:0]  sq;
        logic [2:0][SUM_W-1:0] sum;
    } t_entry;

    typedef struct packed {
        logic                    empty;
        logic [2:0][VAR_W-1:0]   var_fx;
        logic [2:0][MEAN_W-1:0]  mean;
    } t_result;

endpackage

// File: hdl/pixel_background_statistics_core.sv
// Top level of the per-pixel background statistics core.
// Holds the statistics memory, the read-modify-write stage and the divide pipeline.
// Depends on pbs_pkg.
//
// One request per clock is accepted, accumulate or query alike, while
// s_axis_tready is high. After reset the statistics memory is swept to zero, one
// pixel per cycle, with s_axis_tready low. Per-pixel sums and squares live in one
// memory with a registered read; an accumulate reads, adds with saturation and
// writes back in the following cycle, with forwarding between back-to-back requests
// to the same pixel. A query gives a result through the arithmetic front stages and
// a pipeline of restoring divide stages (8 bits for the mean, 18 for the variance).
// Results queue in a 32-entry buffer; s_axis_tready also drops at 32 open queries.
module pixel_background_statistics_core
    import pbs_pkg::*;
#(
    parameter int PIXEL_COUNT = 65536,
    parameter int MAX_FRAMES  = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] pixel_index, [23:16] chan0, [31:24] chan1, [39:32] chan2
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // frame_end
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] mean0, [15:8] mean1, [23:16] mean2, [41:24] var0, [59:42] var1,
    // [77:60] var2, [79:78] zero
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tuser    // model_empty
);

    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int NST = VAR_STEPS + 1;

    // ---------------- input side ----------------
    logic             r_clearing;
    logic [AW-1:0]    r_clr_addr;
    logic [CNT_W-1:0] r_frame_count;
    logic [FIFO_AW:0] r_credit;

    logic          in_accept;
    logic          in_query;
    logic          in_idx_ok;
    logic          cnt_full;
    logic [AW-1:0] in_addr;

    assign s_axis_tready = !r_clearing && (r_credit != (FIFO_AW+1)'(FIFO_DEPTH));
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_query      = (t_opcode'(s_axis_tuser) == OP_QUERY);
    assign in_idx_ok     = (32'(s_axis_tdata[15:0]) < 32'(PIXEL_COUNT));
    assign in_addr       = AW'(s_axis_tdata[15:0]);
    assign cnt_full      = (32'(r_frame_count) >= 32'(MAX_FRAMES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing    <= 1'b1;
            r_clr_addr    <= '0;
            r_frame_count <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(PIXEL_COUNT - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (in_accept && !in_query && !cnt_full && s_axis_tlast) begin
                r_frame_count <= r_frame_count + CNT_W'(1);
            end
        end
    end

    // ---------------- statistics memory ----------------
    t_entry r_mem [PIXEL_COUNT];
    t_entry r_rdata;
    t_entry r_fwd_word;
    logic   r_fwd_hit;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;

    // S1 registers: request whose read data arrives this cycle
    logic              r1_valid, r1_query, r1_write, r1_idx_ok, r1_empty;
    logic [CNT_W-1:0]  r1_n;
    logic [AW-1:0]     r1_addr;
    logic [2:0][7:0]   r1_chan;

    t_entry base;
    t_entry upd;

    always_comb begin
        logic [SUM_W:0] a;
        logic [SQ_W:0]  b;
        base = r_fwd_hit ? r_fwd_word : r_rdata;
        upd  = base;
        for (int c = 0; c < 3; c++) begin
            a = (SUM_W+1)'(base.sum[c]) + (SUM_W+1)'(r1_chan[c]);
            b = (SQ_W+1)'(base.sq[c]) + (SQ_W+1)'(16'(r1_chan[c]) * 16'(r1_chan[c]));
            upd.sum[c] = a[SUM_W] ? '1 : a[SUM_W-1:0];
            upd.sq[c]  = b[SQ_W] ? '1 : b[SQ_W-1:0];
        end
    end

    assign mem_we    = r_clearing || (r1_valid && r1_write);
    assign mem_waddr = r_clearing ? r_clr_addr : r1_addr;
    assign mem_wdata = r_clearing ? '0 : upd;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[in_addr];
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid  <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            r1_valid  <= in_accept;
            r_fwd_hit <= r1_valid && r1_write && (r1_addr == in_addr);
        end
        r_fwd_word <= upd;
        r1_query   <= in_query;
        r1_write   <= !in_query && !cnt_full && in_idx_ok;
        r1_idx_ok  <= in_idx_ok;
        r1_empty   <= (r_frame_count == '0);
        r1_n       <= r_frame_count;
        r1_addr    <= in_addr;
        r1_chan[0] <= s_axis_tdata[23:16];
        r1_chan[1] <= s_axis_tdata[31:24];
        r1_chan[2] <= s_axis_tdata[39:32];
    end

    // ---------------- arithmetic front stages ----------------
    logic                   r2_valid, r2_query, r2_empty;
    logic [CNT_W-1:0]       r2_n;
    logic [2:0][SUM_W-1:0]  r2_s;
    logic [2:0][SQ_W-1:0]   r2_q;

    logic                   r3_valid, r3_query, r3_empty;
    logic [CNT_W-1:0]       r3_n;
    logic [NN_W-1:0]        r3_nn;
    logic [2:0][SUM_W-1:0]  r3_s;
    logic [2:0][PROD_W-1:0] r3_num;
    logic [2:0][PROD_W-1:0] r3_s2;

    logic                   r4_valid, r4_query, r4_empty;
    logic [CNT_W-1:0]       r4_n;
    logic [NN_W-1:0]        r4_nn;
    logic [2:0][SUM_W-1:0]  r4_s;
    logic [2:0][PROD_W-1:0] r4_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
        r2_query <= r1_query;
        r2_empty <= r1_empty;
        r2_n     <= r1_n;
        r3_query <= r2_query;
        r3_empty <= r2_empty;
        r3_n     <= r2_n;
        r3_nn    <= NN_W'(r2_n) * NN_W'(r2_n);
        r4_query <= r3_query;
        r4_empty <= r3_empty;
        r4_n     <= r3_n;
        r4_nn    <= r3_nn;
        for (int c = 0; c < 3; c++) begin
            r2_s[c]   <= r1_idx_ok ? base.sum[c] : '0;
            r2_q[c]   <= r1_idx_ok ? base.sq[c] : '0;
            r3_s[c]   <= r2_s[c];
            r3_num[c] <= PROD_W'(r2_n) * PROD_W'(r2_q[c]);
            r3_s2[c]  <= PROD_W'(r2_s[c]) * PROD_W'(r2_s[c]);
            r4_s[c]   <= r3_s[c];
            r4_diff[c] <= (r3_num[c] > r3_s2[c]) ? (r3_num[c] - r3_s2[c]) : '0;
        end
    end

    // ---------------- divide pipeline ----------------
    logic                   r_p_valid [NST];
    logic                   r_p_query [NST];
    logic                   r_p_empty [NST];
    logic [CNT_W-1:0]       r_p_n     [NST];
    logic [NN_W-1:0]        r_p_nn    [NST];
    logic [2:0][VREM_W-1:0] r_p_vr    [NST];
    logic [2:0][VAR_W-1:0]  r_p_vq    [NST];
    logic [2:0]             r_p_vsat  [NST];
    logic [2:0][SUM_W-1:0]  r_p_mr    [NST];
    logic [2:0][MEAN_W-1:0] r_p_mq    [NST];
    logic [2:0]             r_p_msat  [NST];

    logic [2:0][VREM_W-1:0] n_p_vr [NST];
    logic [2:0][VAR_W-1:0]  n_p_vq [NST];
    logic [2:0][SUM_W-1:0]  n_p_mr [NST];
    logic [2:0][MEAN_W-1:0] n_p_mq [NST];

    always_comb begin
        logic [DNUM_W-1:0] dnum;
        logic [VREM_W-1:0] vt;
        logic [SUM_W-1:0]  mt;
        for (int c = 0; c < 3; c++) begin
            dnum = {r4_diff[c], 4'b0000};
            n_p_vr[0][c] = dnum[VREM_W-1:0];
            n_p_vq[0][c] = '0;
            n_p_mr[0][c] = r4_s[c];
            n_p_mq[0][c] = '0;
        end
        // one quotient bit per stage, most significant first
        for (int k = 0; k < VAR_STEPS; k++) begin
            for (int c = 0; c < 3; c++) begin
                vt = VREM_W'(r_p_nn[k]) << (VAR_STEPS - 1 - k);
                n_p_vr[k+1][c] = r_p_vr[k][c];
                n_p_vq[k+1][c] = r_p_vq[k][c];
                if (r_p_vr[k][c] >= vt) begin
                    n_p_vr[k+1][c] = r_p_vr[k][c] - vt;
                    n_p_vq[k+1][c] = r_p_vq[k][c] | (VAR_W'(1) << (VAR_STEPS - 1 - k));
                end
                n_p_mr[k+1][c] = r_p_mr[k][c];
                n_p_mq[k+1][c] = r_p_mq[k][c];
                if (k < MEAN_STEPS) begin
                    mt = SUM_W'(r_p_n[k]) << (MEAN_STEPS - 1 - k);
                    if (r_p_mr[k][c] >= mt) begin
                        n_p_mr[k+1][c] = r_p_mr[k][c] - mt;
                        n_p_mq[k+1][c] = r_p_mq[k][c] |
                                         (MEAN_W'(1) << (MEAN_STEPS - 1 - k));
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) begin
                r_p_valid[k] <= 1'b0;
            end
        end else begin
            r_p_valid[0] <= r4_valid;
            for (int k = 1; k < NST; k++) begin
                r_p_valid[k] <= r_p_valid[k-1];
            end
        end
        r_p_query[0] <= r4_query;
        r_p_empty[0] <= r4_empty;
        r_p_n[0]     <= r4_n;
        r_p_nn[0]    <= r4_nn;
        for (int c = 0; c < 3; c++) begin
            r_p_vsat[0][c] <= ({r4_diff[c], 4'b0000} >= (DNUM_W'(r4_nn) << VAR_STEPS));
            r_p_msat[0][c] <= (r4_s[c] >= (SUM_W'(r4_n) << MEAN_STEPS));
        end
        for (int k = 0; k < NST; k++) begin
            r_p_vr[k] <= n_p_vr[k];
            r_p_vq[k] <= n_p_vq[k];
            r_p_mr[k] <= n_p_mr[k];
            r_p_mq[k] <= n_p_mq[k];
        end
        for (int k = 1; k < NST; k++) begin
            r_p_query[k] <= r_p_query[k-1];
            r_p_empty[k] <= r_p_empty[k-1];
            r_p_n[k]     <= r_p_n[k-1];
            r_p_nn[k]    <= r_p_nn[k-1];
            r_p_vsat[k]  <= r_p_vsat[k-1];
            r_p_msat[k]  <= r_p_msat[k-1];
        end
    end

    // ---------------- rounding, clamping ----------------
    t_result res;

    always_comb begin
        logic [CNT_W:0]   r2x;
        logic             up;
        logic [VAR_W:0]   vsum;
        for (int c = 0; c < 3; c++) begin
            r2x  = {r_p_mr[VAR_STEPS][c][CNT_W-1:0], 1'b0};
            up   = (r2x > {1'b0, r_p_n[VAR_STEPS]}) ||
                   ((r2x == {1'b0, r_p_n[VAR_STEPS]}) && r_p_mq[VAR_STEPS][c][0]);
            vsum = (VAR_W+1)'(r_p_vq[VAR_STEPS][c]) + (VAR_W+1)'(VAR_OFFSET);
            if (r_p_empty[VAR_STEPS]) begin
                res.mean[c] = '0;
            end else if (r_p_msat[VAR_STEPS][c] ||
                         (up && r_p_mq[VAR_STEPS][c] == MEAN_MAX)) begin
                res.mean[c] = MEAN_MAX;
            end else begin
                res.mean[c] = r_p_mq[VAR_STEPS][c] + MEAN_W'(up);
            end
            if (r_p_empty[VAR_STEPS]) begin
                res.var_fx[c] = VAR_OFFSET;
            end else if (r_p_vsat[VAR_STEPS][c] || vsum[VAR_W]) begin
                res.var_fx[c] = VAR_MAX;
            end else begin
                res.var_fx[c] = vsum[VAR_W-1:0];
            end
        end
        res.empty = r_p_empty[VAR_STEPS];
    end

    // ---------------- result queue ----------------
    t_result              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]     r_fill;
    logic                 push, pop, q_accept;

    assign push     = r_p_valid[VAR_STEPS] && r_p_query[VAR_STEPS];
    assign pop      = m_axis_tvalid && m_axis_tready;
    assign q_accept = in_accept && in_query;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_credit <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_fill   <= r_fill + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
            r_credit <= r_credit + (FIFO_AW+1)'(q_accept) - (FIFO_AW+1)'(pop);
        end
    end

    t_result head;
    assign head          = r_fifo[r_rd_ptr];
    assign m_axis_tvalid = (r_fill != '0);
    assign m_axis_tuser  = head.empty;
    assign m_axis_tdata  = {2'b00, head.var_fx, head.mean};

endmodule
